// ===== rtl/bbs_pkg.sv =====
// shared types and constants for the balanced block size search
`timescale 1ns / 1ps

package bbs_pkg;

    // field widths
    localparam int SIZE_W      = 24;
    localparam int BLOCK_W     = 25;
    localparam int COUNT_OUT_W = 29;
    localparam int RATIO_W     = 24;
    localparam int MUL_W       = 64;
    localparam int PROD_W      = 2 * MUL_W;

    // search constants
    localparam logic [63:0]        LARGE_TOTAL  = 64'd100000000;
    localparam logic [BLOCK_W-1:0] SMALL_STEP   = 25'd256;
    localparam logic [BLOCK_W-1:0] LARGE_STEP   = 25'd16384;
    localparam logic [63:0]        COUNT_FACTOR = 64'd11;
    localparam logic [RATIO_W-1:0] RATIO_ONE    = 24'd65536;
    localparam logic [RATIO_W-1:0] RATIO_RESET  = 24'd6554;

    // register index decoded from paddr[2]
    localparam logic REG_RATIO = 1'b0;

    typedef struct packed {
        logic [SIZE_W-1:0] cluster_size;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [BLOCK_W-1:0]     block_size;
        logic [COUNT_OUT_W-1:0] balanced_count;
        logic                   criterion_met;
    } result_t;

    // handshake of an iterative unit
    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_CAND,
        ST_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_FULL,
        ST_MUL_REM,
        ST_ACC,
        ST_ACC_MQ,
        ST_ACC_TT,
        ST_ACC_P,
        ST_ACC_PM,
        ST_ACC_PM1,
        ST_ACC_RHS,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/bbs_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bbs_div #(
    parameter int DW = 37,
    parameter int VW = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             run_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dvs_reg;
    logic [VW:0]      shifted;
    logic [VW:0]      diff;

    // trial subtract of the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    assign done      = run_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= CNT_W'(DW);
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg && !done)
        begin
            if (!diff[VW])
            begin
                rem_reg <= diff[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/bbs_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle, stops when no bits remain
`timescale 1ns / 1ps

module bbs_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bbs_pkg::MUL_W-1:0] a,
    input  logic [bbs_pkg::MUL_W-1:0] b,
    output logic                      done,
    output logic [bbs_pkg::PROD_W-1:0] product
);

    logic                        run_reg;
    logic [bbs_pkg::PROD_W-1:0]  acc_reg;
    logic [bbs_pkg::PROD_W-1:0]  a_reg;
    logic [bbs_pkg::MUL_W-1:0]   b_reg;

    assign done    = run_reg && (b_reg == '0);
    assign product = acc_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
    end

    // accumulate shifted multiplicand
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= bbs_pkg::PROD_W'(a);
            b_reg   <= b;
        end
        else if (run_reg && !done)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[bbs_pkg::PROD_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[bbs_pkg::MUL_W-1:1]};
        end
    end

endmodule

// ===== rtl/balanced_block_size_search.sv =====
// balanced block size search: cluster store, sequencer, shared divider and multiplier
// a last item starts the divide for the average; per candidate, each stored cluster takes a divide
//   and two multiplies, then the exact variance test runs unless a quick accept applies,
//   then one result cycle; busy high throughout
// throughput: one item per cycle while loading; the result strobe cannot be stalled
// reset clears counters and the ratio register (6554); the size store is not cleared
`timescale 1ns / 1ps

module balanced_block_size_search #(
    parameter int MAX_CLUSTERS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bbs_pkg::item_t       item,
    output logic                 done,
    output bbs_pkg::result_t     result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CW   = $clog2(MAX_CLUSTERS + 1);
    localparam int AW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int TW   = bbs_pkg::SIZE_W + CW;
    localparam int BW   = bbs_pkg::BLOCK_W;
    localparam int MW   = bbs_pkg::MUL_W;
    localparam int PW   = bbs_pkg::PROD_W;
    localparam int OUTW = bbs_pkg::COUNT_OUT_W;
    localparam int SW   = bbs_pkg::SIZE_W;

    bbs_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                 count_reg, count_next;
    logic [TW-1:0]                 total_reg, total_next;
    logic [BW-1:0]                 step_reg, step_next;
    logic [BW-1:0]                 cand_reg, cand_next;
    logic [TW-1:0]                 chunk_reg, chunk_next;
    logic [MW-1:0]                 sq_reg, sq_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [SW-1:0]                 c_reg, c_next;
    logic [BW-1:0]                 rem_reg, rem_next;
    logic [PW-1:0]                 lhs_reg, lhs_next;
    logic [MW-1:0]                 p_reg, p_next;
    logic [MW-1:0]                 pm_reg, pm_next;
    logic                          met_reg, met_next;
    logic [bbs_pkg::RATIO_W-1:0]   ratio_reg;

    // size store
    logic [SW-1:0] mem [MAX_CLUSTERS];
    logic [SW-1:0] rd_data_reg;
    logic          wr_en;
    logic          rd_en;

    // shared units
    bbs_pkg::unit_ctl_t div_ctl;
    bbs_pkg::unit_ctl_t mul_ctl;
    logic [TW-1:0] div_dividend;
    logic [BW-1:0] div_divisor;
    logic [TW-1:0] div_quo;
    logic [BW-1:0] div_rem;
    logic [MW-1:0] mul_a;
    logic [MW-1:0] mul_b;
    logic [PW-1:0] mul_prod;

    logic          accept;
    logic          cfg_wr;
    logic [BW-1:0] avg_q;
    logic [BW-1:0] avg_s;
    logic [BW-1:0] step_sel;
    logic [MW-1:0] m64;
    logic [PW-1:0] diff;

    assign accept = start && !busy;
    assign busy   = (state_reg != bbs_pkg::ST_IDLE);
    assign m64    = MW'(chunk_reg);

    bbs_div #(
        .DW (TW),
        .VW (BW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_ctl.start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_ctl.done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    bbs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_ctl.start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_ctl.done),
        .product (mul_prod)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == bbs_pkg::REG_RATIO) ? 32'(ratio_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= bbs_pkg::RATIO_RESET;
        end
        else if (cfg_wr && (paddr[2] == bbs_pkg::REG_RATIO))
        begin
            ratio_reg <= pwdata[bbs_pkg::RATIO_W-1:0];
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= item.cluster_size;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    // starting candidate from the average
    assign step_sel = (64'(total_reg) > bbs_pkg::LARGE_TOTAL) ? bbs_pkg::LARGE_STEP
                                                             : bbs_pkg::SMALL_STEP;
    assign avg_q    = BW'(div_quo);
    assign avg_s    = avg_q & ~(step_sel - 1'b1);
    assign diff     = (lhs_reg < mul_prod) ? '0 : (lhs_reg - mul_prod);

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbs_pkg::ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            cand_reg  <= '0;
            chunk_reg <= '0;
            sq_reg    <= '0;
            idx_reg   <= '0;
            met_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            cand_reg  <= cand_next;
            chunk_reg <= chunk_next;
            sq_reg    <= sq_next;
            idx_reg   <= idx_next;
            met_reg   <= met_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        c_reg    <= c_next;
        rem_reg  <= rem_next;
        lhs_reg  <= lhs_next;
        p_reg    <= p_next;
        pm_reg   <= pm_next;
    end

    // sequencer next state and unit control
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        step_next     = step_reg;
        cand_next     = cand_reg;
        chunk_next    = chunk_reg;
        sq_next       = sq_reg;
        idx_next      = idx_reg;
        c_next        = c_reg;
        rem_next      = rem_reg;
        lhs_next      = lhs_reg;
        p_next        = p_reg;
        pm_next       = pm_reg;
        met_next      = met_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        div_ctl.start = 1'b0;
        div_dividend  = total_reg;
        div_divisor   = BW'(count_reg);
        mul_ctl.start = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        done          = 1'b0;

        unique case (state_reg)
            bbs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CW'(MAX_CLUSTERS))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        total_next = total_reg + TW'(item.cluster_size);
                    end
                    if (item.last)
                    begin
                        state_next = bbs_pkg::ST_AVG_GO;
                    end
                end
            end
            bbs_pkg::ST_AVG_GO:
            begin
                div_ctl.start = 1'b1;
                state_next    = bbs_pkg::ST_AVG_WAIT;
            end
            bbs_pkg::ST_AVG_WAIT:
            begin
                if (div_ctl.done)
                begin
                    step_next  = step_sel;
                    cand_next  = (avg_s < step_sel) ? step_sel : avg_s;
                    state_next = bbs_pkg::ST_CAND;
                end
            end
            bbs_pkg::ST_CAND:
            begin
                chunk_next = '0;
                sq_next    = '0;
                idx_next   = '0;
                state_next = bbs_pkg::ST_RD;
            end
            bbs_pkg::ST_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = bbs_pkg::ST_ACC;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = bbs_pkg::ST_DIV_GO;
                end
            end
            bbs_pkg::ST_DIV_GO:
            begin
                c_next        = rd_data_reg;
                div_ctl.start = 1'b1;
                div_dividend  = TW'(rd_data_reg);
                div_divisor   = cand_reg;
                state_next    = bbs_pkg::ST_DIV_WAIT;
            end
            bbs_pkg::ST_DIV_WAIT:
            begin
                if (div_ctl.done)
                begin
                    chunk_next    = chunk_reg + div_quo + TW'(div_rem != '0);
                    rem_next      = div_rem;
                    // full blocks contribute (size - remainder) * candidate
                    mul_ctl.start = 1'b1;
                    mul_a         = MW'(c_reg) - MW'(div_rem);
                    mul_b         = MW'(cand_reg);
                    state_next    = bbs_pkg::ST_MUL_FULL;
                end
            end
            bbs_pkg::ST_MUL_FULL:
            begin
                if (mul_ctl.done)
                begin
                    sq_next       = sq_reg + mul_prod[MW-1:0];
                    mul_ctl.start = 1'b1;
                    mul_a         = MW'(rem_reg);
                    mul_b         = MW'(rem_reg);
                    state_next    = bbs_pkg::ST_MUL_REM;
                end
            end
            bbs_pkg::ST_MUL_REM:
            begin
                if (mul_ctl.done)
                begin
                    sq_next    = sq_reg + mul_prod[MW-1:0];
                    idx_next   = idx_reg + 1'b1;
                    state_next = bbs_pkg::ST_RD;
                end
            end
            bbs_pkg::ST_ACC:
            begin
                // quick accepts: many blocks, one block or none, ratio of one or more
                if ((m64 > 64'(count_reg) * bbs_pkg::COUNT_FACTOR) || (m64 <= 64'd1)
                    || (ratio_reg >= bbs_pkg::RATIO_ONE))
                begin
                    met_next   = 1'b1;
                    state_next = bbs_pkg::ST_OUT;
                end
                else
                begin
                    mul_ctl.start = 1'b1;
                    mul_a         = m64;
                    mul_b         = sq_reg;
                    state_next    = bbs_pkg::ST_ACC_MQ;
                end
            end
            bbs_pkg::ST_ACC_MQ:
            begin
                if (mul_ctl.done)
                begin
                    lhs_next      = mul_prod;
                    mul_ctl.start = 1'b1;
                    mul_a         = MW'(total_reg);
                    mul_b         = MW'(total_reg);
                    state_next    = bbs_pkg::ST_ACC_TT;
                end
            end
            bbs_pkg::ST_ACC_TT:
            begin
                if (mul_ctl.done)
                begin
                    // clamped variance numerator scaled by 2^32
                    lhs_next      = {diff[PW-33:0], 32'b0};
                    mul_ctl.start = 1'b1;
                    mul_a         = MW'(ratio_reg);
                    mul_b         = MW'(cand_reg);
                    state_next    = bbs_pkg::ST_ACC_P;
                end
            end
            bbs_pkg::ST_ACC_P:
            begin
                if (mul_ctl.done)
                begin
                    p_next        = mul_prod[MW-1:0];
                    mul_ctl.start = 1'b1;
                    mul_a         = mul_prod[MW-1:0];
                    mul_b         = m64;
                    state_next    = bbs_pkg::ST_ACC_PM;
                end
            end
            bbs_pkg::ST_ACC_PM:
            begin
                if (mul_ctl.done)
                begin
                    pm_next       = mul_prod[MW-1:0];
                    mul_ctl.start = 1'b1;
                    mul_a         = p_reg;
                    mul_b         = m64 - 64'd1;
                    state_next    = bbs_pkg::ST_ACC_PM1;
                end
            end
            bbs_pkg::ST_ACC_PM1:
            begin
                if (mul_ctl.done)
                begin
                    mul_ctl.start = 1'b1;
                    mul_a         = pm_reg;
                    mul_b         = mul_prod[MW-1:0];
                    state_next    = bbs_pkg::ST_ACC_RHS;
                end
            end
            bbs_pkg::ST_ACC_RHS:
            begin
                if (mul_ctl.done)
                begin
                    if (mul_prod >= lhs_reg)
                    begin
                        met_next   = 1'b1;
                        state_next = bbs_pkg::ST_OUT;
                    end
                    else if (cand_reg <= step_reg)
                    begin
                        // fallback to one step
                        cand_next  = step_reg;
                        met_next   = 1'b0;
                        state_next = bbs_pkg::ST_OUT;
                    end
                    else
                    begin
                        cand_next  = cand_reg - step_reg;
                        state_next = bbs_pkg::ST_CAND;
                    end
                end
            end
            bbs_pkg::ST_OUT:
            begin
                done       = 1'b1;
                count_next = '0;
                total_next = '0;
                state_next = bbs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bbs_pkg::ST_IDLE;
            end
        endcase
    end

    // result beat
    assign result.block_size     = cand_reg;
    assign result.balanced_count = OUTW'(chunk_reg);
    assign result.criterion_met  = met_reg;

`ifndef ASSERT_OFF
    a_last_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last) |=> busy)
        else $error("last beat did not start a search");

    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    a_size_step_multiple: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.block_size[7:0] == '0 && result.block_size != '0))
        else $error("block size is not a nonzero multiple of the small step");

    a_fallback_is_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.criterion_met) |->
            (result.block_size == bbs_pkg::SMALL_STEP
             || result.block_size == bbs_pkg::LARGE_STEP))
        else $error("fallback block size is not one step");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (count_reg == '0 && total_reg == '0))
        else $error("set not cleared after result beat");
`endif

endmodule
